@@ rtl/jclr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jclr_pkg: shared types and constants
// Widths, refresh sequence codes, queue item layout and back-end state codes
// for the joystick cursor LCD refresher.
// ----------------------------------------------------------------------------
package jclr_pkg;

    // frame store: 8 pages x 128 columns, one byte per page column
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int JOY_W       = 10;
    localparam int X_W         = 7;
    localparam int Y_W         = 6;
    localparam int PAGE_W      = 3;
    localparam int STEP_W      = 8;

    localparam logic [X_W-1:0]    X_MAX       = 7'd127;
    localparam logic [Y_W-1:0]    Y_MAX       = 6'd63;
    localparam logic [PAGE_W-1:0] PAGE_LAST   = 3'd7;
    localparam logic [BYTE_W-1:0] PAGE_SET    = 8'hB8;
    localparam logic [BYTE_W-1:0] COLUMN_SET  = 8'h40;
    localparam logic [BYTE_W-1:0] STORE_INIT0 = 8'h01;

    // refresh steps within a page: 0..1 page set, 2..3 column set, 4..131 data
    localparam logic [STEP_W-1:0] STEP_COL  = 8'd2;
    localparam logic [STEP_W-1:0] STEP_DATA = 8'd4;
    localparam logic [STEP_W-1:0] STEP_LAST = 8'd131;

    localparam logic [JOY_W-1:0] DEAD_LOW_RST  = 10'd475;
    localparam logic [JOY_W-1:0] DEAD_HIGH_RST = 10'd549;

    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_LOW  = 1'b0,
        CFG_DEAD_HIGH = 1'b1
    } t_cfg_reg;

    // queue between front and back; depth must be a power of two
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_XFER = 1'b1
    } t_cmd;

    // cursor movement, already in cursor terms (y inversion done up front)
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_DEC  = 2'd1,
        DIR_INC  = 2'd2
    } t_dir;

    typedef struct packed {
        t_cmd cmd;
        t_dir x_dir;
        t_dir y_dir;
        logic released;
    } t_item;

    typedef enum logic [2:0] {
        BS_CLEAR    = 3'd0,
        BS_IDLE     = 3'd1,
        BS_TICK_WR  = 3'd2,
        BS_TICK_RMW = 3'd3,
        BS_REF_RD   = 3'd4
    } t_bstate;

endpackage
`default_nettype wire

@@ rtl/joystick_cursor_lcd_refresher_core.sv @@
`default_nettype none
// Path: an accepted beat is queued, then a page or column instruction goes to
//   the output register; a frame tick or data write first takes a store step.
// Throughput: one instruction write per cycle while results are taken; a tick or
//   data write needs a store read, then a write or output, before the next pop; set by the single store port pair.
// Reset: synchronous, active low. A clearing pass then sweeps the 1024-byte
//   store (o_ready low); configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// joystick_cursor_lcd_refresher_core: cursor drawing on a page framebuffer
// 128x64 one-bit frame store in 8-row pages, joystick cursor with pen
// toggle, and a 1056-write controller refresh walker.
// ----------------------------------------------------------------------------
module joystick_cursor_lcd_refresher_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_cmd,
    input  wire logic [jclr_pkg::JOY_W-1:0]     i_joy_x,
    input  wire logic [jclr_pkg::JOY_W-1:0]     i_joy_y,
    input  wire logic                           i_button_released,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_chip,
    output logic                                o_is_data,
    output logic [jclr_pkg::BYTE_W-1:0]         o_bus_byte,
    output logic                                o_frame_end,
    output logic [jclr_pkg::X_W-1:0]            o_cursor_x,
    output logic [jclr_pkg::Y_W-1:0]            o_cursor_y,
    output logic                                o_pen_lifted,
    // register write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [jclr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jclr_pkg::JOY_W-1:0]     i_cfg_data
);

    // front -> queue
    logic            fe_push;
    jclr_pkg::t_item fe_item;
    // queue -> back
    jclr_pkg::t_item q_item;
    logic            q_full;
    logic            q_not_empty;
    logic            be_pop;
    // back -> front: store sweep finished
    logic            be_init_done;

    // Front end: deadband classification happens at accept time, so each
    // queued beat already carries its per-axis move.
    jclr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_joy_x           (i_joy_x),
        .i_joy_y           (i_joy_y),
        .i_button_released (i_button_released),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_full          (q_full),
        .i_init_done       (be_init_done),
        .o_push            (fe_push),
        .o_item            (fe_item)
    );

    // Short queue lets the front keep taking beats while the back works.
    jclr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fe_push),
        .i_item      (fe_item),
        .i_pop       (be_pop),
        .o_item      (q_item),
        .o_full      (q_full),
        .o_not_empty (q_not_empty)
    );

    // Back end: owns the store, cursor, pen, refresh position and the
    // output register. It pops only when the output register is free.
    jclr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_not_empty),
        .i_q_item     (q_item),
        .o_q_pop      (be_pop),
        .o_init_done  (be_init_done),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chip       (o_chip),
        .o_is_data    (o_is_data),
        .o_bus_byte   (o_bus_byte),
        .o_frame_end  (o_frame_end),
        .o_cursor_x   (o_cursor_x),
        .o_cursor_y   (o_cursor_y),
        .o_pen_lifted (o_pen_lifted)
    );

endmodule
`default_nettype wire

@@ rtl/jclr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jclr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module jclr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/jclr_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jclr_fifo: short item queue
// Decouples the classifying front end from the store sequencer.
// ----------------------------------------------------------------------------
module jclr_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  jclr_pkg::t_item     i_item,
    input  wire logic           i_pop,
    output jclr_pkg::t_item     o_item,
    output logic                o_full,
    output logic                o_not_empty
);

    jclr_pkg::t_item                    r_mem [jclr_pkg::FIFO_DEPTH];
    logic [jclr_pkg::FIFO_PTR_W-1:0]    r_wr_ptr;
    logic [jclr_pkg::FIFO_PTR_W-1:0]    r_rd_ptr;
    logic [jclr_pkg::FIFO_CNT_W-1:0]    r_count;
    logic [jclr_pkg::FIFO_CNT_W-1:0]    n_count;

    assign o_full      = (r_count == jclr_pkg::FIFO_CNT_W'(jclr_pkg::FIFO_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/jclr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jclr_front: input stage
// Holds the deadband registers, accepts beats and turns joystick samples
// into per-axis cursor moves before queueing.
// ----------------------------------------------------------------------------
module jclr_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_cmd,
    input  wire logic [jclr_pkg::JOY_W-1:0]     i_joy_x,
    input  wire logic [jclr_pkg::JOY_W-1:0]     i_joy_y,
    input  wire logic                           i_button_released,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [jclr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jclr_pkg::JOY_W-1:0]     i_cfg_data,
    input  wire logic                           i_q_full,
    input  wire logic                           i_init_done,
    output logic                                o_push,
    output jclr_pkg::t_item                     o_item
);

    logic [jclr_pkg::JOY_W-1:0] r_dead_low;
    logic [jclr_pkg::JOY_W-1:0] r_dead_high;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full && i_init_done;
    assign o_push      = i_valid && o_ready;

    // low test wins over high test
    always_comb begin
        o_item.cmd      = jclr_pkg::t_cmd'(i_cmd);
        o_item.released = i_button_released;
        if (i_joy_x < r_dead_low) begin
            o_item.x_dir = jclr_pkg::DIR_DEC;
        end else if (i_joy_x > r_dead_high) begin
            o_item.x_dir = jclr_pkg::DIR_INC;
        end else begin
            o_item.x_dir = jclr_pkg::DIR_NONE;
        end
        // y axis inverted: low sample moves down the screen
        if (i_joy_y < r_dead_low) begin
            o_item.y_dir = jclr_pkg::DIR_INC;
        end else if (i_joy_y > r_dead_high) begin
            o_item.y_dir = jclr_pkg::DIR_DEC;
        end else begin
            o_item.y_dir = jclr_pkg::DIR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_low  <= jclr_pkg::DEAD_LOW_RST;
            r_dead_high <= jclr_pkg::DEAD_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (jclr_pkg::t_cfg_reg'(i_cfg_index))
                jclr_pkg::CFG_DEAD_LOW:  r_dead_low  <= i_cfg_data;
                jclr_pkg::CFG_DEAD_HIGH: r_dead_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/jclr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jclr_back: store sequencer
// Clears the frame store after reset, applies frame ticks to the cursor and
// store, walks the refresh sequence and fills the output register.
// ----------------------------------------------------------------------------
module jclr_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  jclr_pkg::t_item                    i_q_item,
    output logic                               o_q_pop,
    output logic                               o_init_done,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_chip,
    output logic                               o_is_data,
    output logic [jclr_pkg::BYTE_W-1:0]        o_bus_byte,
    output logic                               o_frame_end,
    output logic [jclr_pkg::X_W-1:0]           o_cursor_x,
    output logic [jclr_pkg::Y_W-1:0]           o_cursor_y,
    output logic                               o_pen_lifted
);

    localparam int AW = jclr_pkg::ADDR_W;

    jclr_pkg::t_bstate            r_state, n_state;
    logic [AW-1:0]                r_clr_addr, n_clr_addr;
    logic [jclr_pkg::X_W-1:0]     r_cur_x, n_cur_x;
    logic [jclr_pkg::Y_W-1:0]     r_cur_y, n_cur_y;
    logic                         r_pen_up, n_pen_up;
    logic                         r_press_seen, n_press_seen;
    logic [jclr_pkg::PAGE_W-1:0]  r_ref_page, n_ref_page;
    logic [jclr_pkg::STEP_W-1:0]  r_ref_step, n_ref_step;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_chip, n_out_chip;
    logic                         r_out_is_data, n_out_is_data;
    logic [jclr_pkg::BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic                         r_out_fend, n_out_fend;
    logic                         r_pend_chip, n_pend_chip;
    logic                         r_pend_fend, n_pend_fend;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [jclr_pkg::BYTE_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [jclr_pkg::BYTE_W-1:0]  ram_rdata;

    logic                         out_free;
    logic                         tk_pen, tk_press;
    logic [jclr_pkg::X_W-1:0]     tk_x;
    logic [jclr_pkg::Y_W-1:0]     tk_y;
    logic [AW-1:0]                idx_cur, idx_new;
    logic [jclr_pkg::BYTE_W-1:0]  pix_mask;
    logic [jclr_pkg::STEP_W-1:0]  data_k;
    logic [AW-1:0]                ref_addr;
    logic                         ref_fend;
    logic [jclr_pkg::BYTE_W-1:0]  instr_byte;

    jclr_ram #(
        .WIDTH (jclr_pkg::BYTE_W),
        .DEPTH (jclr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_init_done  = (r_state != jclr_pkg::BS_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_chip       = r_out_chip;
    assign o_is_data    = r_out_is_data;
    assign o_bus_byte   = r_out_byte;
    assign o_frame_end  = r_out_fend;
    // no item is taken while a result waits, so these match the result
    assign o_cursor_x   = r_cur_x;
    assign o_cursor_y   = r_cur_y;
    assign o_pen_lifted = r_pen_up;

    assign out_free = !r_out_valid || i_ready;

    // frame tick: button edge, then saturating one-step move
    always_comb begin
        tk_pen   = r_pen_up;
        tk_press = r_press_seen;
        if (i_q_item.released) begin
            if (r_press_seen) begin
                tk_pen   = !r_pen_up;
                tk_press = 1'b0;
            end
        end else begin
            tk_press = 1'b1;
        end

        tk_x = r_cur_x;
        case (i_q_item.x_dir)
            jclr_pkg::DIR_DEC: if (r_cur_x != '0) tk_x = r_cur_x - 1'b1;
            jclr_pkg::DIR_INC: if (r_cur_x != jclr_pkg::X_MAX) tk_x = r_cur_x + 1'b1;
            default: ;
        endcase
        tk_y = r_cur_y;
        case (i_q_item.y_dir)
            jclr_pkg::DIR_DEC: if (r_cur_y != '0) tk_y = r_cur_y - 1'b1;
            jclr_pkg::DIR_INC: if (r_cur_y != jclr_pkg::Y_MAX) tk_y = r_cur_y + 1'b1;
            default: ;
        endcase
    end

    assign idx_cur  = {r_cur_y[jclr_pkg::Y_W-1:3], r_cur_x};
    assign idx_new  = {tk_y[jclr_pkg::Y_W-1:3], tk_x};
    assign pix_mask = jclr_pkg::BYTE_W'(1) << r_cur_y[2:0];

    // refresh position -> store address: page, half, column within half
    assign data_k     = r_ref_step - jclr_pkg::STEP_DATA;
    assign ref_addr   = {r_ref_page, data_k[0], data_k[6:1]};
    assign ref_fend   = (r_ref_page == jclr_pkg::PAGE_LAST) &&
                        (r_ref_step == jclr_pkg::STEP_LAST);
    assign instr_byte = (r_ref_step < jclr_pkg::STEP_COL) ?
                        (jclr_pkg::PAGE_SET | jclr_pkg::BYTE_W'(r_ref_page)) :
                        jclr_pkg::COLUMN_SET;

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_pen_up      = r_pen_up;
        n_press_seen  = r_press_seen;
        n_ref_page    = r_ref_page;
        n_ref_step    = r_ref_step;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_chip    = r_out_chip;
        n_out_is_data = r_out_is_data;
        n_out_byte    = r_out_byte;
        n_out_fend    = r_out_fend;
        n_pend_chip   = r_pend_chip;
        n_pend_fend   = r_pend_fend;
        ram_we        = 1'b0;
        ram_waddr     = idx_cur;
        ram_wdata     = '0;
        ram_raddr     = idx_new;
        o_q_pop       = 1'b0;

        unique case (r_state)
            jclr_pkg::BS_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = (r_clr_addr == '0) ? jclr_pkg::STORE_INIT0 : '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = jclr_pkg::BS_IDLE;
                end
            end
            jclr_pkg::BS_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.cmd == jclr_pkg::CMD_TICK) begin
                        n_cur_x      = tk_x;
                        n_cur_y      = tk_y;
                        n_pen_up     = tk_pen;
                        n_press_seen = tk_press;
                        if (tk_pen) begin
                            // pen up: wipe the old cursor byte first
                            ram_we    = 1'b1;
                            ram_waddr = idx_cur;
                            n_state   = jclr_pkg::BS_TICK_WR;
                        end else begin
                            ram_raddr = idx_new;
                            n_state   = jclr_pkg::BS_TICK_RMW;
                        end
                    end else begin
                        if (r_ref_step == jclr_pkg::STEP_LAST) begin
                            n_ref_step = '0;
                            n_ref_page = r_ref_page + 1'b1;
                        end else begin
                            n_ref_step = r_ref_step + 1'b1;
                        end
                        if (r_ref_step < jclr_pkg::STEP_DATA) begin
                            n_out_valid   = 1'b1;
                            n_out_chip    = r_ref_step[0];
                            n_out_is_data = 1'b0;
                            n_out_byte    = instr_byte;
                            n_out_fend    = 1'b0;
                        end else begin
                            ram_raddr   = ref_addr;
                            n_pend_chip = r_ref_step[0];
                            n_pend_fend = ref_fend;
                            n_state     = jclr_pkg::BS_REF_RD;
                        end
                    end
                end
            end
            jclr_pkg::BS_TICK_WR, jclr_pkg::BS_TICK_RMW: begin
                ram_we        = 1'b1;
                ram_waddr     = idx_cur;
                ram_wdata     = (r_state == jclr_pkg::BS_TICK_WR) ? pix_mask :
                                (ram_rdata | pix_mask);
                n_out_valid   = 1'b1;
                n_out_chip    = 1'b0;
                n_out_is_data = 1'b0;
                n_out_byte    = '0;
                n_out_fend    = 1'b0;
                n_state       = jclr_pkg::BS_IDLE;
            end
            jclr_pkg::BS_REF_RD: begin
                n_out_valid   = 1'b1;
                n_out_chip    = r_pend_chip;
                n_out_is_data = 1'b1;
                n_out_byte    = ram_rdata;
                n_out_fend    = r_pend_fend;
                n_state       = jclr_pkg::BS_IDLE;
            end
            default: begin
                n_state = jclr_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= jclr_pkg::BS_CLEAR;
            r_clr_addr   <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_pen_up     <= 1'b1;
            r_press_seen <= 1'b0;
            r_ref_page   <= '0;
            r_ref_step   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_pen_up     <= n_pen_up;
            r_press_seen <= n_press_seen;
            r_ref_page   <= n_ref_page;
            r_ref_step   <= n_ref_step;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_chip    <= n_out_chip;
        r_out_is_data <= n_out_is_data;
        r_out_byte    <= n_out_byte;
        r_out_fend    <= n_out_fend;
        r_pend_chip   <= n_pend_chip;
        r_pend_fend   <= n_pend_fend;
    end

endmodule
`default_nettype wire

@@ rtl/jclr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jclr_checker: port-level checks
// Watches the top-level ports; bound to the core below.
// ----------------------------------------------------------------------------
module jclr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_ready,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic                       o_chip,
    input wire logic                       o_is_data,
    input wire logic [jclr_pkg::BYTE_W-1:0] o_bus_byte,
    input wire logic                       o_frame_end
);

    // store sweep follows reset: no beats taken right after it
    a_ready_low_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("item ready right after reset");

    // stalled result keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bus_byte))
        else $error("stalled result changed");

    // last refresh write is a right-half data byte
    a_frame_end_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_is_data && o_chip)
        else $error("frame end on a non-data or left write");

    // instruction bytes are page set, column set, or the zero tick result
    a_instr_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_data |->
            (o_bus_byte == jclr_pkg::COLUMN_SET) ||
            ((o_bus_byte & 8'hF8) == jclr_pkg::PAGE_SET) ||
            (o_bus_byte == 8'h00 && !o_chip))
        else $error("bad instruction byte");

endmodule

bind joystick_cursor_lcd_refresher_core jclr_checker u_jclr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_chip      (o_chip),
    .o_is_data   (o_is_data),
    .o_bus_byte  (o_bus_byte),
    .o_frame_end (o_frame_end)
);
`default_nettype wire

@@ test/joystick_cursor_lcd_refresher_core_tb.sv @@
// ----------------------------------------------------------------------------
// joystick_cursor_lcd_refresher_core_tb: cursor drawing and refresh check
// Drives frame ticks and transfer requests with random gaps, keeps its own
// copy of the page store, cursor, pen and refresh walker, and compares every
// result beat field by field against the predicted controller write.
// ----------------------------------------------------------------------------
module joystick_cursor_lcd_refresher_core_tb;

    import jclr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    // reset + store clearing pass + long receiver hold, with margin
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 100;   // results seen before the long hold
    localparam int SIDE_TX       = 0;
    localparam int SIDE_RX       = 1;
    localparam logic [JOY_W-1:0] JOY_TOP = 10'd1023;

    // one host beat as offered on the item channel
    typedef struct packed {
        t_cmd             cmd;
        logic [JOY_W-1:0] joy_x;
        logic [JOY_W-1:0] joy_y;
        logic             released;
    } t_stick_beat;

    // one controller write plus cursor status, as seen on the result channel
    typedef struct packed {
        logic              chip;
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
        logic              frame_end;
        logic [X_W-1:0]    cursor_x;
        logic [Y_W-1:0]    cursor_y;
        logic              pen_lifted;
    } t_lcd_write;

    // ------------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_valid           = 1'b0;
    logic              o_ready;
    t_cmd              i_cmd             = CMD_TICK;
    logic [JOY_W-1:0]  i_joy_x           = '0;
    logic [JOY_W-1:0]  i_joy_y           = '0;
    logic              i_button_released = 1'b1;
    logic              o_valid;
    logic              i_ready           = 1'b0;
    logic              o_chip;
    logic              o_is_data;
    logic [BYTE_W-1:0] o_bus_byte;
    logic              o_frame_end;
    logic [X_W-1:0]    o_cursor_x;
    logic [Y_W-1:0]    o_cursor_y;
    logic              o_pen_lifted;
    logic              i_cfg_valid       = 1'b0;
    logic              o_cfg_ready;
    t_cfg_reg          i_cfg_index       = CFG_DEAD_LOW;
    logic [JOY_W-1:0]  i_cfg_data        = '0;

    joystick_cursor_lcd_refresher_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_joy_x           (i_joy_x),
        .i_joy_y           (i_joy_y),
        .i_button_released (i_button_released),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_chip            (o_chip),
        .o_is_data         (o_is_data),
        .o_bus_byte        (o_bus_byte),
        .o_frame_end       (o_frame_end),
        .o_cursor_x        (o_cursor_x),
        .o_cursor_y        (o_cursor_y),
        .o_pen_lifted      (o_pen_lifted),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow of the block: page store, cursor, pen, button latch, walker
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] pixel_bytes [STORE_DEPTH];
    logic [X_W-1:0]    cur_col;
    logic [Y_W-1:0]    cur_row;
    logic              pen_up;
    logic              press_armed;
    logic [PAGE_W-1:0] walk_page;
    logic [STEP_W-1:0] walk_step;
    logic [JOY_W-1:0]  dz_low;
    logic [JOY_W-1:0]  dz_high;

    t_stick_beat       host_beats[$];       // waiting to be offered
    t_lcd_write        expected_writes[$];  // predicted, not yet seen

    int unsigned beats_queued  = 0;
    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned tx_gap        = 0;
    int unsigned rx_gap        = 0;
    int unsigned hold_left     = 0;
    int unsigned burst_left[2] = '{0, 0};
    bit          pressure_done = 1'b0;
    bit          in_taken      = 1'b0;   // item beat at the last rising edge
    bit          out_taken     = 1'b0;   // result beat at the last rising edge

    task automatic reset_shadow();
        foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
        pixel_bytes[0] = STORE_INIT0;
        cur_col     = '0;
        cur_row     = '0;
        pen_up      = 1'b1;
        press_armed = 1'b0;
        walk_page   = '0;
        walk_step   = '0;
        dz_low      = DEAD_LOW_RST;
        dz_high     = DEAD_HIGH_RST;
    endtask

    // Advance the shadow by one accepted beat and queue the write it yields.
    task automatic predict_panel_write(input t_stick_beat sb);
        t_lcd_write        w;
        logic [ADDR_W-1:0] addr;
        logic [STEP_W-1:0] k;
        w = '0;
        if (sb.cmd == CMD_TICK) begin
            // pen toggles on a release that follows a press
            if (sb.released) begin
                if (press_armed) begin
                    pen_up      = ~pen_up;
                    press_armed = 1'b0;
                end
            end else begin
                press_armed = 1'b1;
            end
            if (pen_up)
                pixel_bytes[{cur_row[5:3], cur_col}] = '0;
            // low test wins even with dead_low above dead_high
            if (sb.joy_x < dz_low) begin
                if (cur_col != '0) cur_col--;
            end else if (sb.joy_x > dz_high) begin
                if (cur_col != X_MAX) cur_col++;
            end
            // y is inverted: low sample moves down the screen
            if (sb.joy_y < dz_low) begin
                if (cur_row != Y_MAX) cur_row++;
            end else if (sb.joy_y > dz_high) begin
                if (cur_row != '0) cur_row--;
            end
            addr = {cur_row[5:3], cur_col};
            if (pen_up)
                pixel_bytes[addr] = 8'd1 << cur_row[2:0];
            else
                pixel_bytes[addr] = pixel_bytes[addr] | (8'd1 << cur_row[2:0]);
        end else begin
            w.frame_end = (walk_page == PAGE_LAST) && (walk_step == STEP_LAST);
            if (walk_step < STEP_COL) begin
                w.chip     = walk_step[0];
                w.bus_byte = PAGE_SET | BYTE_W'(walk_page);
            end else if (walk_step < STEP_DATA) begin
                w.chip     = walk_step[0];
                w.bus_byte = COLUMN_SET;
            end else begin
                // data pairs: left column y, then right column y+64
                k          = walk_step - STEP_DATA;
                w.chip     = k[0];
                w.is_data  = 1'b1;
                w.bus_byte = pixel_bytes[{walk_page, k[0], k[6:1]}];
            end
            if (walk_step == STEP_LAST) begin
                walk_step = '0;
                walk_page = walk_page + 1'b1;
            end else begin
                walk_step = walk_step + 1'b1;
            end
        end
        w.cursor_x   = cur_col;
        w.cursor_y   = cur_row;
        w.pen_lifted = pen_up;
        expected_writes.push_back(w);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Gap lengths: mostly none or short, a few long, with idle-free bursts
    // ------------------------------------------------------------------------
    function automatic int unsigned gap_len(input int side);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_left[side] != 0) begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: item channel, changes on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_stick_beat nxt;
        if (!(i_valid && !in_taken)) begin
            if (i_valid && in_taken)
                tx_gap = gap_len(SIDE_TX);
            if (tx_gap != 0 || host_beats.size() == 0) begin
                if (tx_gap != 0) tx_gap--;
                i_valid <= 1'b0;
            end else begin
                nxt = host_beats.pop_front();
                i_valid           <= 1'b1;
                i_cmd             <= nxt.cmd;
                i_joy_x           <= nxt.joy_x;
                i_joy_y           <= nxt.joy_y;
                i_button_released <= nxt.released;
            end
        end
        // else: beat still waiting for ready, payload held
    end

    // ------------------------------------------------------------------------
    // Receiver: result channel ready, with one long hold-off so the block
    // fills up and pushes back on the item channel
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        if (!pressure_done && results_seen >= HOLD_AFTER) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (out_taken)
            rx_gap = gap_len(SIDE_RX);
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the result beat first, then predict the item beat, so
    // the queue order never depends on process order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_lcd_write  want;
        t_stick_beat sb;
        out_taken = o_valid && i_ready;
        in_taken  = i_valid && o_ready;
        if (out_taken) begin
            results_seen++;
            if (expected_writes.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, bus_byte %0h",
                         $time, o_bus_byte);
            end else begin
                want = expected_writes.pop_front();
                check_field("chip",       want.chip,       o_chip);
                check_field("is_data",    want.is_data,    o_is_data);
                check_field("bus_byte",   want.bus_byte,   o_bus_byte);
                check_field("frame_end",  want.frame_end,  o_frame_end);
                check_field("cursor_x",   want.cursor_x,   o_cursor_x);
                check_field("cursor_y",   want.cursor_y,   o_cursor_y);
                check_field("pen_lifted", want.pen_lifted, o_pen_lifted);
            end
        end
        if (in_taken) begin
            sb.cmd      = i_cmd;
            sb.joy_x    = i_joy_x;
            sb.joy_y    = i_joy_y;
            sb.released = i_button_released;
            predict_panel_write(sb);
            beats_sent++;
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_tick(input logic [JOY_W-1:0] jx, input logic [JOY_W-1:0] jy,
                              input logic rel);
        host_beats.push_back('{CMD_TICK, jx, jy, rel});
        beats_queued++;
    endtask

    task automatic queue_xfer(input int n);
        repeat (n) begin
            // joystick fields are don't-care here, keep them moving anyway
            host_beats.push_back('{CMD_XFER, JOY_W'($urandom), JOY_W'($urandom),
                                   1'($urandom)});
            beats_queued++;
        end
    endtask

    // lean: -1 toward low samples, +1 toward high, 0 none
    function automatic logic [JOY_W-1:0] joy_sample(input int lean);
        int pick;
        int lo;
        int hi;
        if ($urandom_range(0, 7) == 0)
            return JOY_W'($urandom_range(0, 1023));
        if (lean != 0 && $urandom_range(0, 99) < 60)
            pick = lean;
        else
            pick = int'($urandom_range(0, 2)) - 1;
        lo = (dz_low < dz_high) ? int'(dz_low) : int'(dz_high);
        hi = (dz_low < dz_high) ? int'(dz_high) : int'(dz_low);
        if (pick < 0)
            return JOY_W'($urandom_range(0, dz_low));
        if (pick > 0)
            return JOY_W'($urandom_range(dz_high, 1023));
        return JOY_W'($urandom_range(lo, hi));
    endfunction

    task automatic queue_random(input int n, input int xfer_pct, input int x_lean,
                                input int y_lean, input int press_pct);
        @(posedge i_clk);
        repeat (n) begin
            if ($urandom_range(0, 99) < xfer_pct)
                queue_xfer(1);
            else
                queue_tick(joy_sample(x_lean), joy_sample(y_lean),
                           $urandom_range(0, 99) >= press_pct);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [JOY_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DEAD_LOW)
            dz_low = val;
        else
            dz_high = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // all offered beats taken and all results back, then a latency margin
    task automatic wait_drained();
        do @(negedge i_clk);
        while (beats_sent != beats_queued || expected_writes.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        reset_shadow();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: walker start, deadband edges, saturation, pen toggling
        queue_xfer(6);                          // page/column sets, first data pair
        queue_tick(10'd0, JOY_TOP, 1'b1);       // both axes pinned at the origin
        queue_tick(JOY_TOP, 10'd0, 1'b1);
        queue_tick(10'd474, 10'd474, 1'b1);     // just below dead_low
        queue_tick(10'd475, 10'd549, 1'b1);     // on the band edges: no move
        queue_tick(10'd550, 10'd550, 1'b1);     // just above dead_high
        queue_tick(10'd512, 10'd512, 1'b0);     // press
        queue_tick(10'd512, 10'd512, 1'b1);     // release: pen down
        queue_tick(JOY_TOP, 10'd0, 1'b1);       // trail
        queue_tick(JOY_TOP, 10'd0, 1'b1);
        queue_tick(10'd512, 10'd512, 1'b1);     // release without press
        queue_tick(10'd512, 10'd512, 1'b0);
        queue_tick(10'd0, JOY_TOP, 1'b0);       // held press while moving
        queue_tick(10'd512, 10'd512, 1'b1);     // pen up again, byte cleared
        queue_xfer(4);
        queue_tick(JOY_TOP, JOY_TOP, 1'b1);
        wait_drained();

        // band covering everything: nothing moves
        write_reg(CFG_DEAD_LOW, 10'd0);
        write_reg(CFG_DEAD_HIGH, JOY_TOP);
        queue_random(60, 40, -1, 1, 20);
        wait_drained();

        // inverted band: low test wins, drift to left edge and bottom row
        write_reg(CFG_DEAD_LOW, JOY_TOP);
        write_reg(CFG_DEAD_HIGH, 10'd0);
        queue_random(80, 20, 0, 0, 15);
        wait_drained();

        // wide band, drift right and up
        write_reg(CFG_DEAD_LOW, 10'd300);
        write_reg(CFG_DEAD_HIGH, 10'd700);
        queue_random(80, 45, 1, 1, 15);
        wait_drained();

        // back to the power-on band, drawing with the pen toggling often
        write_reg(CFG_DEAD_LOW, DEAD_LOW_RST);
        write_reg(CFG_DEAD_HIGH, DEAD_HIGH_RST);
        queue_random(80, 55, -1, -1, 30);
        wait_drained();

        // random band
        write_reg(CFG_DEAD_LOW, JOY_W'($urandom_range(0, 1023)));
        write_reg(CFG_DEAD_HIGH, JOY_W'($urandom_range(0, 1023)));
        queue_random(80, 60, 0, 0, 20);
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
